// ===== hdl/sflbp_pkg.sv =====
// shared constants, types and codes for the striped free list buffer pool
`default_nettype none

package sflbp_pkg;

    // pool geometry
    localparam int POOLS    = 2;
    localparam int SLICES   = 1024;
    localparam int SUBPOOLS = 4;
    localparam int PER      = SLICES / SUBPOOLS;
    localparam int PER_DIV  = (PER > 0) ? PER : 1;

    // derived widths
    localparam int SLICE_W = $clog2(SLICES);
    localparam int SUB_W   = (SUBPOOLS > 1) ? $clog2(SUBPOOLS) : 1;
    localparam int CNT_W   = (PER > 0) ? $clog2(PER + 1) : 1;
    localparam int IDX_W   = $clog2(POOLS * SUBPOOLS);
    localparam int MEM_DEPTH = POOLS * SLICES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int PROD_W    = SLICE_W + 16;

    // fixed field types
    typedef logic [15:0] bytes_t;
    typedef logic [47:0] addr_t;
    typedef logic [7:0]  hdr_t;
    typedef logic [2:0]  status_t;
    typedef logic [10:0] slice_in_t;
    typedef logic [9:0]  slice_out_t;
    typedef logic [1:0]  sub_out_t;
    typedef logic [8:0]  count_out_t;
    typedef logic [2:0]  cfg_idx_t;

    // internal types
    typedef logic [SLICE_W-1:0] slice_t;
    typedef logic [SUB_W-1:0]   sub_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [MEM_AW-1:0]  mem_addr_t;
    typedef logic [PROD_W-1:0]  prod_t;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam status_t STS_OK         = 3'd0;
    localparam status_t STS_TOO_LARGE  = 3'd1;
    localparam status_t STS_EMPTY      = 3'd2;
    localparam status_t STS_BAD_HANDLE = 3'd3;
    localparam status_t STS_REF_ERR    = 3'd4;

    // configuration register indexes
    localparam cfg_idx_t REG_SMALL_LIMIT  = 3'd0;
    localparam cfg_idx_t REG_LARGE_LIMIT  = 3'd1;
    localparam cfg_idx_t REG_SMALL_BASE   = 3'd2;
    localparam cfg_idx_t REG_LARGE_BASE   = 3'd3;
    localparam cfg_idx_t REG_SMALL_STRIDE = 3'd4;
    localparam cfg_idx_t REG_LARGE_STRIDE = 3'd5;
    localparam cfg_idx_t REG_HEADER       = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic take;
        logic eval;
        logic pop_data;
        logic commit_use;
        logic commit_free;
        logic load_out;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic eval_final;
        logic is_alloc;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/sflbp_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module sflbp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/sflbp_ctrl.sv =====
// sequencing state machine for the buffer pool
`default_nettype none

module sflbp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sflbp_pkg::dp_sts_t sts,
    output sflbp_pkg::ctl_cmd_t     cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_USE   = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (sts.eval_final) begin
                    if (sts.out_free) begin
                        cmd.eval     = 1'b1;
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.eval   = 1'b1;
                    state_next = sts.is_alloc ? S_POP : S_FREE;
                end
            end
            S_POP: begin
                cmd.pop_data = 1'b1;
                state_next   = S_USE;
            end
            S_USE: begin
                if (sts.out_free) begin
                    cmd.commit_use = 1'b1;
                    cmd.load_out   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FREE: begin
                if (sts.out_free) begin
                    cmd.commit_free = 1'b1;
                    cmd.load_out    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sflbp_dp.sv =====
// datapath: config registers, stack and in-use memories, depth counters, result register
`default_nettype none

module sflbp_dp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire sflbp_pkg::cfg_idx_t    cfg_addr,
    input  wire sflbp_pkg::addr_t       cfg_wr_data,
    input  wire logic                   s_kind,
    input  wire logic                   s_pool,
    input  wire sflbp_pkg::bytes_t      s_request_bytes,
    input  wire sflbp_pkg::slice_in_t   s_slice,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output sflbp_pkg::status_t          m_status,
    output sflbp_pkg::slice_out_t       m_granted_slice,
    output sflbp_pkg::addr_t            m_data_address,
    output sflbp_pkg::sub_out_t         m_subpool,
    output sflbp_pkg::count_out_t       m_free_count,
    input  wire sflbp_pkg::ctl_cmd_t    cmd,
    output sflbp_pkg::dp_sts_t          sts
);

    localparam int NSTK = sflbp_pkg::POOLS * sflbp_pkg::SUBPOOLS;

    // configuration
    sflbp_pkg::bytes_t small_limit_reg, large_limit_reg;
    sflbp_pkg::addr_t  small_base_reg, large_base_reg;
    sflbp_pkg::bytes_t small_stride_reg, large_stride_reg;
    sflbp_pkg::hdr_t   header_reg;

    // latched transaction
    logic                 kind_reg;
    logic                 pool_reg;
    sflbp_pkg::bytes_t    req_reg;
    sflbp_pkg::slice_in_t slice_reg;

    // per-stack state
    sflbp_pkg::cnt_t depth_reg [NSTK];
    sflbp_pkg::cnt_t low_reg   [NSTK];
    sflbp_pkg::sub_t rr_reg    [sflbp_pkg::POOLS];

    // working registers
    sflbp_pkg::sub_t      sub_reg;
    sflbp_pkg::cnt_t      count_reg;
    sflbp_pkg::idx_t      idx_reg;
    logic                 fresh_reg;
    sflbp_pkg::slice_t    rst_val_reg;
    sflbp_pkg::slice_t    got_reg;
    sflbp_pkg::prod_t     prod_reg;
    sflbp_pkg::mem_addr_t clr_cnt_reg;

    // result register
    logic                   out_valid_reg;
    sflbp_pkg::status_t     out_status_reg;
    sflbp_pkg::slice_out_t  out_slice_reg;
    sflbp_pkg::addr_t       out_addr_reg;
    sflbp_pkg::sub_out_t    out_sub_reg;
    sflbp_pkg::count_out_t  out_count_reg;

    // combinational
    logic                 is_alloc;
    sflbp_pkg::bytes_t    limit;
    logic                 too_large;
    sflbp_pkg::sub_t      rr_cur;
    sflbp_pkg::sub_t      rr_next;
    logic                 slice_ok;
    sflbp_pkg::sub_t      home;
    sflbp_pkg::sub_t      sel_sub;
    sflbp_pkg::idx_t      idx;
    sflbp_pkg::cnt_t      d_cur;
    sflbp_pkg::cnt_t      low_cur;
    sflbp_pkg::cnt_t      d_pop;
    logic                 empty;
    logic                 do_pop;
    sflbp_pkg::bytes_t    stride;
    sflbp_pkg::addr_t     base;
    sflbp_pkg::slice_t    got;
    sflbp_pkg::addr_t     alloc_addr;
    logic                 use_bit;
    logic                 push_ok;

    // memory ports
    logic                 stk_wr_en, stk_rd_en;
    sflbp_pkg::mem_addr_t stk_wr_addr, stk_rd_addr;
    sflbp_pkg::slice_t    stk_rd_data;
    logic                 use_wr_en, use_rd_en;
    sflbp_pkg::mem_addr_t use_wr_addr, use_rd_addr;
    logic [0:0]           use_wr_data, use_rd_data;

    // result mux
    sflbp_pkg::status_t    res_status;
    sflbp_pkg::slice_out_t res_slice;
    sflbp_pkg::addr_t      res_addr;
    sflbp_pkg::sub_out_t   res_sub;
    sflbp_pkg::count_out_t res_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_limit_reg  <= '0;
            large_limit_reg  <= '0;
            small_base_reg   <= '0;
            large_base_reg   <= '0;
            small_stride_reg <= 16'd1;
            large_stride_reg <= 16'd1;
            header_reg       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sflbp_pkg::REG_SMALL_LIMIT:  small_limit_reg  <= cfg_wr_data[15:0];
                sflbp_pkg::REG_LARGE_LIMIT:  large_limit_reg  <= cfg_wr_data[15:0];
                sflbp_pkg::REG_SMALL_BASE:   small_base_reg   <= cfg_wr_data;
                sflbp_pkg::REG_LARGE_BASE:   large_base_reg   <= cfg_wr_data;
                sflbp_pkg::REG_SMALL_STRIDE: small_stride_reg <= cfg_wr_data[15:0];
                sflbp_pkg::REG_LARGE_STRIDE: large_stride_reg <= cfg_wr_data[15:0];
                sflbp_pkg::REG_HEADER:       header_reg       <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            kind_reg  <= s_kind;
            pool_reg  <= s_pool;
            req_reg   <= s_request_bytes;
            slice_reg <= s_slice;
        end
    end

    // request evaluation
    always_comb begin
        is_alloc  = (kind_reg == sflbp_pkg::KIND_ALLOC);
        limit     = pool_reg ? large_limit_reg : small_limit_reg;
        too_large = (req_reg > limit);
        rr_cur    = rr_reg[pool_reg];
        rr_next   = (rr_cur == sflbp_pkg::sub_t'(sflbp_pkg::SUBPOOLS - 1)) ? '0 : rr_cur + 1'b1;
        slice_ok  = (int'(slice_reg) < sflbp_pkg::SUBPOOLS * sflbp_pkg::PER);
        home      = sflbp_pkg::sub_t'(int'(slice_reg) / sflbp_pkg::PER_DIV);
        sel_sub   = is_alloc ? rr_cur : home;
        idx       = sflbp_pkg::idx_t'(int'(pool_reg) * sflbp_pkg::SUBPOOLS + int'(sel_sub));
        d_cur     = depth_reg[idx];
        low_cur   = low_reg[idx];
        d_pop     = d_cur - 1'b1;
        empty     = (d_cur == '0) || (d_cur > sflbp_pkg::cnt_t'(sflbp_pkg::PER));
        do_pop    = cmd.eval && is_alloc && !too_large && !empty;
        stride    = pool_reg ? large_stride_reg : small_stride_reg;
        base      = pool_reg ? large_base_reg : small_base_reg;
        // positions below the lowest depth ever reached still hold their reset contents
        got       = fresh_reg ? rst_val_reg : stk_rd_data;
        alloc_addr = base + sflbp_pkg::addr_t'(prod_reg) + sflbp_pkg::addr_t'(header_reg);
        use_bit   = use_rd_data[0];
        push_ok   = (count_reg < sflbp_pkg::cnt_t'(sflbp_pkg::PER));
    end

    assign sts.eval_final = is_alloc ? (too_large || empty) : !slice_ok;
    assign sts.is_alloc   = is_alloc;
    assign sts.clear_done = (clr_cnt_reg == sflbp_pkg::mem_addr_t'(sflbp_pkg::MEM_DEPTH - 1));
    assign sts.out_free   = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTK; i++) begin
                depth_reg[i] <= sflbp_pkg::cnt_t'(sflbp_pkg::PER);
                low_reg[i]   <= sflbp_pkg::cnt_t'(sflbp_pkg::PER);
            end
            for (int p = 0; p < sflbp_pkg::POOLS; p++) begin
                rr_reg[p] <= '0;
            end
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.clear_en) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.eval && is_alloc && !too_large) begin
                rr_reg[pool_reg] <= rr_next;
            end
            if (do_pop) begin
                depth_reg[idx] <= d_pop;
                if (low_cur > d_pop) begin
                    low_reg[idx] <= d_pop;
                end
            end
            if (cmd.commit_free && use_bit && push_ok) begin
                depth_reg[idx_reg] <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            idx_reg     <= idx;
            sub_reg     <= sel_sub;
            count_reg   <= is_alloc ? d_pop : d_cur;
            fresh_reg   <= (low_cur >= d_cur);
            rst_val_reg <= sflbp_pkg::slice_t'(int'(rr_cur) * sflbp_pkg::PER + int'(d_pop));
        end
        if (cmd.pop_data) begin
            got_reg  <= got;
            prod_reg <= sflbp_pkg::prod_t'(got * stride);
        end
    end

    // free stacks
    always_comb begin
        stk_rd_en   = do_pop;
        stk_rd_addr = sflbp_pkg::mem_addr_t'(int'(pool_reg) * sflbp_pkg::SLICES
                      + int'(rr_cur) * sflbp_pkg::PER + int'(d_pop));
        stk_wr_en   = cmd.commit_free && use_bit && push_ok;
        stk_wr_addr = sflbp_pkg::mem_addr_t'(int'(pool_reg) * sflbp_pkg::SLICES
                      + int'(sub_reg) * sflbp_pkg::PER + int'(count_reg));
    end

    sflbp_ram #(
        .WIDTH (sflbp_pkg::SLICE_W),
        .DEPTH (sflbp_pkg::MEM_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (sflbp_pkg::slice_t'(slice_reg)),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // in-use bits
    always_comb begin
        use_rd_en   = (cmd.eval && !is_alloc && slice_ok) || cmd.pop_data;
        use_rd_addr = cmd.pop_data
                    ? sflbp_pkg::mem_addr_t'(int'(pool_reg) * sflbp_pkg::SLICES + int'(got))
                    : sflbp_pkg::mem_addr_t'(int'(pool_reg) * sflbp_pkg::SLICES
                      + int'(sflbp_pkg::slice_t'(slice_reg)));
        use_wr_en   = 1'b0;
        use_wr_addr = clr_cnt_reg;
        use_wr_data = 1'b0;
        if (cmd.clear_en) begin
            use_wr_en = 1'b1;
        end else if (cmd.commit_use) begin
            use_wr_en   = !use_bit;
            use_wr_addr = sflbp_pkg::mem_addr_t'(int'(pool_reg) * sflbp_pkg::SLICES
                          + int'(got_reg));
            use_wr_data = 1'b1;
        end else if (cmd.commit_free) begin
            use_wr_en   = use_bit;
            use_wr_addr = sflbp_pkg::mem_addr_t'(int'(pool_reg) * sflbp_pkg::SLICES
                          + int'(sflbp_pkg::slice_t'(slice_reg)));
        end
    end

    sflbp_ram #(
        .WIDTH (1),
        .DEPTH (sflbp_pkg::MEM_DEPTH)
    ) u_use_ram (
        .aclk    (aclk),
        .wr_en   (use_wr_en),
        .wr_addr (use_wr_addr),
        .wr_data (use_wr_data),
        .rd_en   (use_rd_en),
        .rd_addr (use_rd_addr),
        .rd_data (use_rd_data)
    );

    // result selection
    always_comb begin
        res_status = sflbp_pkg::STS_OK;
        res_slice  = '0;
        res_addr   = '0;
        res_sub    = sflbp_pkg::sub_out_t'(sub_reg);
        res_count  = sflbp_pkg::count_out_t'(count_reg);
        if (cmd.commit_use) begin
            if (use_bit) begin
                res_status = sflbp_pkg::STS_REF_ERR;
            end else begin
                res_slice = sflbp_pkg::slice_out_t'(got_reg);
                res_addr  = alloc_addr;
            end
        end else if (cmd.commit_free) begin
            if (!use_bit) begin
                res_status = sflbp_pkg::STS_REF_ERR;
            end else if (push_ok) begin
                res_count = sflbp_pkg::count_out_t'(count_reg + 1'b1);
            end
        end else begin
            res_count = '0;
            if (!is_alloc) begin
                res_status = sflbp_pkg::STS_BAD_HANDLE;
                res_sub    = '0;
            end else if (too_large) begin
                res_status = sflbp_pkg::STS_TOO_LARGE;
                res_sub    = '0;
            end else begin
                res_status = sflbp_pkg::STS_EMPTY;
                res_sub    = sflbp_pkg::sub_out_t'(rr_cur);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= res_status;
            out_slice_reg  <= res_slice;
            out_addr_reg   <= res_addr;
            out_sub_reg    <= res_sub;
            out_count_reg  <= res_count;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_granted_slice = out_slice_reg;
    assign m_data_address  = out_addr_reg;
    assign m_subpool       = out_sub_reg;
    assign m_free_count    = out_count_reg;

endmodule

`default_nettype wire

// ===== hdl/striped_free_list_buffer_pool_unit.sv =====
// top level of the striped free list buffer pool
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  s_       | in        | s_valid / s_ready   | kind, pool, request_bytes, slice
//  m_       | out       | m_valid / m_ready   | status, granted_slice, data_address,
//           |           |                     | subpool, free_count
//  cfg_     | in        | cfg_wr_en           | cfg_addr (register index), cfg_wr_data
//
// one transaction at a time; an allocate that pops a slice goes accept, evaluate, pop, commit;
//   a free that passes the range check goes accept, evaluate, commit; a refused one accept, evaluate
// the allocate path waits on two dependent registered ram reads: free stack, then in-use bit
// after reset the in-use ram is swept clear, all 2048 entries, with s_ready low;
//   config writes are taken during the sweep
// a finished result waits in the output register while the next transaction is accepted;
//   a held result stalls the block only when the next one is ready to leave
`default_nettype none

module striped_free_list_buffer_pool_unit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire sflbp_pkg::cfg_idx_t   cfg_addr,
    input  wire sflbp_pkg::addr_t      cfg_wr_data,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic                  s_pool,
    input  wire sflbp_pkg::bytes_t     s_request_bytes,
    input  wire sflbp_pkg::slice_in_t  s_slice,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sflbp_pkg::status_t         m_status,
    output sflbp_pkg::slice_out_t      m_granted_slice,
    output sflbp_pkg::addr_t           m_data_address,
    output sflbp_pkg::sub_out_t        m_subpool,
    output sflbp_pkg::count_out_t      m_free_count
);

    // command and status between sequencer and datapath
    sflbp_pkg::ctl_cmd_t cmd;
    sflbp_pkg::dp_sts_t  sts;

    // sequencer: clear sweep, accept, evaluate, pop, commit
    sflbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: stacks, in-use bits, depth and round-robin counters, address math
    sflbp_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_kind          (s_kind),
        .s_pool          (s_pool),
        .s_request_bytes (s_request_bytes),
        .s_slice         (s_slice),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_slice (m_granted_slice),
        .m_data_address  (m_data_address),
        .m_subpool       (m_subpool),
        .m_free_count    (m_free_count),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

`default_nettype wire

// ===== hdl/sflbp_checker.sv =====
// port-level checks for the buffer pool top, attached by bind
`default_nettype none

module sflbp_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_wr_en,
    input wire sflbp_pkg::cfg_idx_t   cfg_addr,
    input wire sflbp_pkg::addr_t      cfg_wr_data,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  s_kind,
    input wire logic                  s_pool,
    input wire sflbp_pkg::bytes_t     s_request_bytes,
    input wire sflbp_pkg::slice_in_t  s_slice,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire sflbp_pkg::status_t    m_status,
    input wire sflbp_pkg::slice_out_t m_granted_slice,
    input wire sflbp_pkg::addr_t      m_data_address,
    input wire sflbp_pkg::sub_out_t   m_subpool,
    input wire sflbp_pkg::count_out_t m_free_count
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_granted_slice)
            && $stable(m_data_address) && $stable(m_subpool) && $stable(m_free_count))
        else $error("result changed while stalled");

    // one transaction in flight: not ready right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted back to back");

    // reset starts the clearing sweep
    a_reset_not_ready: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready right after reset");

    // a new result is produced only while the request side is busy
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work in progress");

endmodule

bind striped_free_list_buffer_pool_unit sflbp_checker u_sflbp_checker (.*);

`default_nettype wire

// ===== sim/tb_striped_free_list_buffer_pool_unit.sv =====
// self-checking testbench for the striped free list buffer pool: directed rows, then random
`default_nettype none

module tb_striped_free_list_buffer_pool_unit;
    import sflbp_pkg::*;

    // clocking and run length
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 16;      // quiet time after the last result
    localparam int LONG_HOLD      = 300;     // receiver hold-off, long enough to back up input
    localparam int TIMEOUT_CYCLES = 400000;  // sweep + ~2k transactions, many times over

    // pool select codes
    localparam logic P_SMALL = 1'b0;
    localparam logic P_LARGE = 1'b1;

    // directed row: expectation typed in, or left to the predictor
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        logic       kind;
        logic       pool;
        bytes_t     request_bytes;
        slice_in_t  slice;
    } pool_req_t;

    typedef struct packed {
        status_t    status;
        slice_out_t granted;
        addr_t      addr;
        sub_out_t   sub;
        count_out_t count;
    } pool_result_t;

    typedef struct packed {
        pool_req_t    req;
        logic         typed;
        pool_result_t want;
    } directed_row_t;

    typedef struct packed {
        bytes_t small_limit;
        bytes_t large_limit;
        addr_t  small_base;
        addr_t  large_base;
        bytes_t small_stride;
        bytes_t large_stride;
        hdr_t   header;
    } pool_cfg_t;

    localparam pool_result_t NONE      = '0;
    localparam pool_cfg_t    RESET_CFG = '{16'd0, 16'd0, 48'd0, 48'd0, 16'd1, 16'd1, 8'd0};

    // directed rows, run with the register values that reset leaves:
    // limits 0, bases 0, strides 1, no header, so the data address equals the slice
    localparam directed_row_t DIRECTED [22] = '{
        // first pops take the top of each small stack, highest slice first
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, TYPED, '{STS_OK, 10'd255, 48'd255, 2'd0, 9'd255}},
        // any size above a zero limit is refused, counter untouched
        '{'{KIND_ALLOC, P_SMALL, 16'hFFFF, 11'd0}, TYPED, '{STS_TOO_LARGE, 10'd0, 48'd0, 2'd0, 9'd0}},
        '{'{KIND_ALLOC, P_SMALL, 16'd1, 11'd0}, TYPED, '{STS_TOO_LARGE, 10'd0, 48'd0, 2'd0, 9'd0}},
        // large pool keeps its own counter and stacks
        '{'{KIND_ALLOC, P_LARGE, 16'd0, 11'd0}, TYPED, '{STS_OK, 10'd255, 48'd255, 2'd0, 9'd255}},
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, TYPED, '{STS_OK, 10'd511, 48'd511, 2'd1, 9'd255}},
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, TYPED, '{STS_OK, 10'd767, 48'd767, 2'd2, 9'd255}},
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, TYPED, '{STS_OK, 10'd1023, 48'd1023, 2'd3, 9'd255}},
        // counter wraps back to the first stack
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, TYPED, '{STS_OK, 10'd254, 48'd254, 2'd0, 9'd254}},
        // free of the top slice refills its home stack
        '{'{KIND_FREE, P_SMALL, 16'd0, 11'd1023}, TYPED, '{STS_OK, 10'd0, 48'd0, 2'd3, 9'd256}},
        // double free
        '{'{KIND_FREE, P_SMALL, 16'd0, 11'd1023}, TYPED, '{STS_REF_ERR, 10'd0, 48'd0, 2'd3, 9'd256}},
        // handles past the last slice
        '{'{KIND_FREE, P_SMALL, 16'd0, 11'd1024}, TYPED, '{STS_BAD_HANDLE, 10'd0, 48'd0, 2'd0, 9'd0}},
        '{'{KIND_FREE, P_SMALL, 16'd0, 11'd2047}, TYPED, '{STS_BAD_HANDLE, 10'd0, 48'd0, 2'd0, 9'd0}},
        // free of a slice never handed out, then of one that was
        '{'{KIND_FREE, P_LARGE, 16'd0, 11'd0}, TYPED, '{STS_REF_ERR, 10'd0, 48'd0, 2'd0, 9'd255}},
        '{'{KIND_FREE, P_LARGE, 16'd0, 11'd255}, TYPED, '{STS_OK, 10'd0, 48'd0, 2'd0, 9'd256}},
        // ignored fields at their extremes
        '{'{KIND_ALLOC, P_LARGE, 16'd0, 11'd2047}, TYPED, '{STS_OK, 10'd511, 48'd511, 2'd1, 9'd255}},
        '{'{KIND_FREE, P_SMALL, 16'hFFFF, 11'd255}, TYPED, '{STS_OK, 10'd0, 48'd0, 2'd0, 9'd255}},
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, PRED, NONE},
        '{'{KIND_FREE, P_SMALL, 16'd0, 11'd0}, PRED, NONE},
        '{'{KIND_FREE, P_LARGE, 16'd0, 11'd511}, PRED, NONE},
        '{'{KIND_ALLOC, P_LARGE, 16'd0, 11'd0}, PRED, NONE},
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, PRED, NONE},
        // freed slice comes straight back off the stack
        '{'{KIND_ALLOC, P_SMALL, 16'd0, 11'd0}, PRED, NONE}
    };

    // block ports, inputs all at known values from time zero
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    cfg_idx_t   cfg_addr    = REG_SMALL_LIMIT;
    addr_t      cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_kind      = KIND_ALLOC;
    logic       s_pool      = P_SMALL;
    bytes_t     s_request_bytes = '0;
    slice_in_t  s_slice     = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    status_t    m_status;
    slice_out_t m_granted_slice;
    addr_t      m_data_address;
    sub_out_t   m_subpool;
    count_out_t m_free_count;

    // predictor state: settings, free stacks, stack fill, round-robin pointers, in-use bits
    pool_cfg_t   model_cfg;
    slice_out_t  stack_mem  [POOLS][SLICES];
    int unsigned stack_fill [POOLS][SUBPOOLS];
    int unsigned next_sub   [POOLS];
    bit          slice_held [POOLS][SLICES];
    int unsigned held_total [POOLS];

    // results owed by the block, oldest first
    pool_result_t pending_results [$];

    // run bookkeeping
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned status_seen [8];
    int unsigned rx_stall_pct    = 0;
    bit          hold_pending    = 1'b0;

    striped_free_list_buffer_pool_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_pool          (s_pool),
        .s_request_bytes (s_request_bytes),
        .s_slice         (s_slice),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_slice (m_granted_slice),
        .m_data_address  (m_data_address),
        .m_subpool       (m_subpool),
        .m_free_count    (m_free_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // stacks full and in ascending order, so pops hand out the highest slice first
    function automatic void reset_model();
        model_cfg = RESET_CFG;
        for (int p = 0; p < POOLS; p++) begin
            next_sub[p]   = 0;
            held_total[p] = 0;
            for (int s = 0; s < SUBPOOLS; s++) begin
                stack_fill[p][s] = PER;
                for (int j = 0; j < PER; j++)
                    stack_mem[p][s * PER + j] = slice_out_t'(s * PER + j);
            end
            for (int i = 0; i < SLICES; i++)
                slice_held[p][i] = 1'b0;
        end
    endfunction

    // outcome of one alloc or free, updating the pool state as the block would
    function automatic pool_result_t serve_request(pool_req_t r);
        pool_result_t res;
        int unsigned  p;
        int unsigned  sub;
        int unsigned  depth;
        int unsigned  got;
        int unsigned  home;
        bytes_t       limit;
        res = '0;
        p   = r.pool;
        if (r.kind == KIND_ALLOC) begin
            limit = p ? model_cfg.large_limit : model_cfg.small_limit;
            if (r.request_bytes > limit) begin
                res.status = STS_TOO_LARGE;
                return res;
            end
            // pointer moves on even when the chosen stack turns out empty
            sub         = next_sub[p];
            next_sub[p] = (sub + 1) % SUBPOOLS;
            depth       = stack_fill[p][sub];
            res.sub     = sub_out_t'(sub);
            if (depth == 0 || depth > PER) begin
                res.status = STS_EMPTY;
                return res;
            end
            depth            = depth - 1;
            stack_fill[p][sub] = depth;
            got              = stack_mem[p][sub * PER + depth] % SLICES;
            res.count        = count_out_t'(depth);
            // a popped slice already marked in use is dropped
            if (slice_held[p][got]) begin
                res.status = STS_REF_ERR;
                return res;
            end
            slice_held[p][got] = 1'b1;
            held_total[p]++;
            res.status  = STS_OK;
            res.granted = slice_out_t'(got);
            res.addr    = (p ? model_cfg.large_base : model_cfg.small_base)
                        + addr_t'(got) * addr_t'(p ? model_cfg.large_stride
                                                   : model_cfg.small_stride)
                        + addr_t'(model_cfg.header);
            return res;
        end
        if (PER == 0 || r.slice >= SUBPOOLS * PER) begin
            res.status = STS_BAD_HANDLE;
            return res;
        end
        home      = r.slice / PER;
        depth     = stack_fill[p][home];
        res.sub   = sub_out_t'(home);
        if (!slice_held[p][r.slice]) begin
            res.status = STS_REF_ERR;
            res.count  = count_out_t'(depth);
            return res;
        end
        slice_held[p][r.slice] = 1'b0;
        held_total[p]--;
        // push onto a full stack is dropped
        if (depth < PER) begin
            stack_mem[p][home * PER + depth] = slice_out_t'(r.slice);
            depth = depth + 1;
            stack_fill[p][home] = depth;
        end
        res.status = STS_OK;
        res.count  = count_out_t'(depth);
        return res;
    endfunction

    // some slice of the pool that is handed out, searched from a random start
    function automatic slice_in_t pick_held(logic pool);
        int unsigned start;
        int unsigned idx;
        start = $urandom_range(SLICES - 1);
        for (int i = 0; i < SLICES; i++) begin
            idx = (start + i) % SLICES;
            if (slice_held[pool][idx])
                return slice_in_t'(idx);
        end
        return '0;
    endfunction

    // mostly legal allocs and frees of held slices; noise adds oversize and bogus frees
    function automatic pool_req_t make_request(int alloc_pct, int large_pct, int noise_pct);
        pool_req_t r;
        bytes_t    limit;
        bit        noisy;
        r.pool          = ($urandom_range(99) < large_pct) ? P_LARGE : P_SMALL;
        r.request_bytes = bytes_t'($urandom);
        r.slice         = slice_in_t'($urandom);
        noisy           = ($urandom_range(99) < noise_pct);
        limit           = r.pool ? model_cfg.large_limit : model_cfg.small_limit;
        if ($urandom_range(99) < alloc_pct || held_total[r.pool] == 0) begin
            r.kind = KIND_ALLOC;
            if (noisy && limit != 16'hFFFF)
                r.request_bytes = bytes_t'($urandom_range(16'hFFFF, int'(limit) + 1));
            else begin
                case ($urandom_range(3))
                    0:       r.request_bytes = '0;
                    1:       r.request_bytes = limit;
                    default: r.request_bytes = bytes_t'($urandom_range(int'(limit)));
                endcase
            end
        end else begin
            r.kind = KIND_FREE;
            if (!noisy)
                r.slice = pick_held(r.pool);
            else if ($urandom_range(1) == 1)
                r.slice = slice_in_t'($urandom_range(2047, SUBPOOLS * PER));
            else
                r.slice = slice_in_t'($urandom_range(SUBPOOLS * PER - 1));
        end
        return r;
    endfunction

    function automatic pool_cfg_t random_settings();
        pool_cfg_t c;
        c.small_limit  = bytes_t'($urandom_range(16'hFFFF));
        c.large_limit  = bytes_t'($urandom_range(16'hFFFF));
        c.small_base   = addr_t'({$urandom, $urandom});
        c.large_base   = addr_t'({$urandom, $urandom});
        c.small_stride = bytes_t'($urandom_range(16'hFFFF, 1));
        c.large_stride = bytes_t'($urandom_range(16'hFFFF, 1));
        c.header       = hdr_t'($urandom_range(255));
        return c;
    endfunction

    task automatic put_reg(cfg_idx_t idx, addr_t value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    // only called with the block idle, so the model can switch over at once
    task automatic load_settings(pool_cfg_t c);
        put_reg(REG_SMALL_LIMIT, addr_t'(c.small_limit));
        put_reg(REG_LARGE_LIMIT, addr_t'(c.large_limit));
        put_reg(REG_SMALL_BASE, c.small_base);
        put_reg(REG_LARGE_BASE, c.large_base);
        put_reg(REG_SMALL_STRIDE, addr_t'(c.small_stride));
        put_reg(REG_LARGE_STRIDE, addr_t'(c.large_stride));
        put_reg(REG_HEADER, addr_t'(c.header));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        model_cfg = c;
    endtask

    // offer one transaction and hold it until taken; valid stays up for the caller
    task automatic issue_request(pool_req_t r, logic typed, pool_result_t want);
        pool_result_t outcome;
        s_valid         <= 1'b1;
        s_kind          <= r.kind;
        s_pool          <= r.pool;
        s_request_bytes <= r.request_bytes;
        s_slice         <= r.slice;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: model steps in the same process, so the next
        // random pick already sees the updated in-use bits
        outcome = serve_request(r);
        pending_results.push_back(typed ? want : outcome);
        requests_sent++;
    endtask

    // sender goes quiet until every owed result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random traffic; sender idles per cycle with tx_pct, receiver stalls with rx_pct
    task automatic run_phase(int items, int tx_pct, int rx_pct,
                             int alloc_pct, int large_pct, int noise_pct);
        rx_stall_pct = rx_pct;
        repeat (items) begin
            issue_request(make_request(alloc_pct, large_pct, noise_pct), PRED, NONE);
            while ($urandom_range(99) < tx_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    task automatic check_field(string field, logic [47:0] want, logic [47:0] seen);
        if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
            mismatch_count++;
        end
    endtask

    // result side: random stalls, plus one long hold-off counted here
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // every result taken is matched against the oldest owed one
    always @(posedge aclk) begin : result_check
        pool_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing owed: status %0d slice %0d",
                       m_status, m_granted_slice);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 48'(want.status), 48'(m_status));
                check_field("granted_slice", 48'(want.granted), 48'(m_granted_slice));
                check_field("data_address", want.addr, m_data_address);
                check_field("subpool", 48'(want.sub), 48'(m_subpool));
                check_field("free_count", 48'(want.count), 48'(m_free_count));
            end
            results_checked++;
            status_seen[m_status]++;
        end
    end

    initial begin : stimulus
        pool_cfg_t settings;
        reset_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows under reset settings; the first waits out the in-use sweep
        rx_stall_pct = 0;
        foreach (DIRECTED[i])
            issue_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
        drain_results();

        // large pool area near the top of the address space so addresses wrap;
        // receiver holds off while the sender keeps pushing
        settings = '{16'd128, 16'hFFFF, 48'h0000_1000_0000, 48'hFFFF_FFFF_F000,
                     16'd64, 16'd2048, 8'd16};
        load_settings(settings);
        hold_pending = 1'b1;
        run_phase(150, 0, 0, 60, 50, 15);
        drain_results();

        // every register at its top value; sender pauses halfway until drained
        settings = '{16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                     16'hFFFF, 16'hFFFF, 8'hFF};
        load_settings(settings);
        run_phase(75, 57, 0, 60, 50, 15);
        drain_results();
        run_phase(75, 57, 0, 60, 50, 15);
        drain_results();

        // bottom values: zero limits leave only zero-byte allocs
        load_settings(RESET_CFG);
        run_phase(150, 0, 57, 60, 50, 15);
        drain_results();

        load_settings(random_settings());
        run_phase(150, 18, 18, 60, 50, 15);
        drain_results();

        // alloc-heavy on the large pool until its stacks run dry, under every idle mix
        settings             = random_settings();
        settings.large_limit = 16'hFFFF;
        load_settings(settings);
        run_phase(325, 0, 0, 98, 97, 3);
        run_phase(325, 57, 0, 98, 97, 3);
        run_phase(325, 0, 57, 98, 97, 3);
        run_phase(325, 18, 18, 98, 97, 3);
        drain_results();

        $display("run: %0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, mismatch_count);
        $display("run: ok %0d, too large %0d, empty %0d, bad handle %0d, ref error %0d",
                 status_seen[STS_OK], status_seen[STS_TOO_LARGE], status_seen[STS_EMPTY],
                 status_seen[STS_BAD_HANDLE], status_seen[STS_REF_ERR]);
        if (mismatch_count == 0) begin
            $display("tb_striped_free_list_buffer_pool_unit: PASS");
        end else begin
            $display("tb_striped_free_list_buffer_pool_unit: FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_striped_free_list_buffer_pool_unit: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
